/* src/rpt_pkg.sv */
`timescale 1ns / 1ps

package rpt_pkg;

    // kept table
    localparam int MAX_KEPT = 1024;
    localparam int ADDR_W   = $clog2(MAX_KEPT);
    localparam int CNT_W    = $clog2(MAX_KEPT + 1);

    // field widths
    localparam int COORD_W  = 16;
    localparam int RAD_W    = 34;
    localparam int SQ_W     = 2 * COORD_W;

    // front queue, depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        point_t pt;
        logic   last;
    } item_t;

    // front to back handshake
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage

/* src/rpt_front.sv */
`timescale 1ns / 1ps

module rpt_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rpt_pkg::COORD_W-1:0]   coord_x,
    input  logic signed [rpt_pkg::COORD_W-1:0]   coord_y,
    input  logic signed [rpt_pkg::COORD_W-1:0]   coord_z,
    input  logic                                 last_point,
    output rpt_pkg::queue_head_t                 head,
    input  logic                                 pop
);

    rpt_pkg::item_t               entry_reg [rpt_pkg::QUEUE_DEPTH];
    logic [rpt_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [rpt_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [rpt_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [rpt_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [rpt_pkg::QCNT_W-1:0]   fill_reg;
    logic [rpt_pkg::QCNT_W-1:0]   fill_next;
    logic                         push;
    logic                         do_pop;
    rpt_pkg::item_t               new_item;

    // full queue holds the sender off
    assign in_stall = (fill_reg == rpt_pkg::QCNT_W'(rpt_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (fill_reg != '0);

    // classify the incoming word into a point and its end marker
    always_comb
    begin
        new_item.pt.x = coord_x;
        new_item.pt.y = coord_y;
        new_item.pt.z = coord_z;
        new_item.last = last_point;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (fill_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

/* src/rpt_back.sv */
`timescale 1ns / 1ps

module rpt_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [rpt_pkg::RAD_W-1:0]            radius_squared,
    input  rpt_pkg::queue_head_t                 head,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rpt_pkg::COORD_W-1:0]   out_x,
    output logic signed [rpt_pkg::COORD_W-1:0]   out_y,
    output logic signed [rpt_pkg::COORD_W-1:0]   out_z,
    output logic                                 keep,
    output logic                                 table_full,
    output logic                                 end_of_cloud
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                          state_reg;
    logic                          state_next;

    // kept table
    rpt_pkg::point_t               kept_mem [rpt_pkg::MAX_KEPT];
    rpt_pkg::point_t               rd_data_reg;
    logic [rpt_pkg::CNT_W-1:0]     count_reg;
    logic [rpt_pkg::CNT_W-1:0]     count_next;

    // point under test
    rpt_pkg::item_t                cur_reg;

    // scan pipeline
    logic [rpt_pkg::CNT_W-1:0]     issue_idx_reg;
    logic [rpt_pkg::CNT_W-1:0]     issue_idx_next;
    logic                          issuing;
    logic                          s1_valid_reg;
    logic                          s2_valid_reg;
    logic                          hit_reg;
    logic                          hit_next;
    logic [rpt_pkg::SQ_W-1:0]      sq_x_reg;
    logic [rpt_pkg::SQ_W-1:0]      sq_y_reg;
    logic [rpt_pkg::SQ_W-1:0]      sq_z_reg;
    logic [rpt_pkg::COORD_W:0]     dx;
    logic [rpt_pkg::COORD_W:0]     dy;
    logic [rpt_pkg::COORD_W:0]     dz;
    logic [rpt_pkg::COORD_W-1:0]   ax;
    logic [rpt_pkg::COORD_W-1:0]   ay;
    logic [rpt_pkg::COORD_W-1:0]   az;
    logic [rpt_pkg::RAD_W-1:0]     dist_sq;
    logic                          scan_done;
    logic                          commit;
    logic                          is_full;
    logic                          keep_now;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    rpt_pkg::point_t               out_pt_reg;
    logic                          keep_reg;
    logic                          full_reg;
    logic                          last_reg;

    assign pop     = (state_reg == ST_IDLE) && head.valid;
    assign issuing = (state_reg == ST_SCAN) && (issue_idx_reg < count_reg) && !hit_reg;

    // abs differences against the table entry just read
    always_comb
    begin
        dx = {cur_reg.pt.x[rpt_pkg::COORD_W-1], cur_reg.pt.x}
           - {rd_data_reg.x[rpt_pkg::COORD_W-1], rd_data_reg.x};
        dy = {cur_reg.pt.y[rpt_pkg::COORD_W-1], cur_reg.pt.y}
           - {rd_data_reg.y[rpt_pkg::COORD_W-1], rd_data_reg.y};
        dz = {cur_reg.pt.z[rpt_pkg::COORD_W-1], cur_reg.pt.z}
           - {rd_data_reg.z[rpt_pkg::COORD_W-1], rd_data_reg.z};
        ax = dx[rpt_pkg::COORD_W] ? rpt_pkg::COORD_W'(-dx) : dx[rpt_pkg::COORD_W-1:0];
        ay = dy[rpt_pkg::COORD_W] ? rpt_pkg::COORD_W'(-dy) : dy[rpt_pkg::COORD_W-1:0];
        az = dz[rpt_pkg::COORD_W] ? rpt_pkg::COORD_W'(-dz) : dz[rpt_pkg::COORD_W-1:0];
    end

    assign dist_sq = {2'b00, sq_x_reg} + {2'b00, sq_y_reg} + {2'b00, sq_z_reg};

    assign scan_done = ((issue_idx_reg >= count_reg) || hit_reg)
                       && !s1_valid_reg && !s2_valid_reg;
    assign commit    = (state_reg == ST_SCAN) && scan_done
                       && (!out_valid_reg || !out_stall);
    assign is_full   = (count_reg == rpt_pkg::CNT_W'(rpt_pkg::MAX_KEPT));
    assign keep_now  = !hit_reg && !is_full;

    always_comb
    begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        hit_next       = hit_reg;
        count_next     = count_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next     = ST_SCAN;
                    issue_idx_next = '0;
                    hit_next       = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (issuing)
                begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                if (s2_valid_reg && (dist_sq <= radius_squared))
                begin
                    hit_next = 1'b1;
                end
                if (commit)
                begin
                    state_next = ST_IDLE;
                    if (cur_reg.last)
                    begin
                        count_next = '0;
                    end
                    else if (keep_now)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            hit_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            hit_reg       <= hit_next;
            s1_valid_reg  <= issuing;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head.item;
        end
        sq_x_reg <= {{rpt_pkg::COORD_W{1'b0}}, ax} * {{rpt_pkg::COORD_W{1'b0}}, ax};
        sq_y_reg <= {{rpt_pkg::COORD_W{1'b0}}, ay} * {{rpt_pkg::COORD_W{1'b0}}, ay};
        sq_z_reg <= {{rpt_pkg::COORD_W{1'b0}}, az} * {{rpt_pkg::COORD_W{1'b0}}, az};
        if (commit)
        begin
            out_pt_reg <= cur_reg.pt;
            keep_reg   <= keep_now;
            full_reg   <= !hit_reg && is_full;
            last_reg   <= cur_reg.last;
        end
    end

    // kept table memory
    always_ff @(posedge clk)
    begin
        if (commit && keep_now)
        begin
            kept_mem[count_reg[rpt_pkg::ADDR_W-1:0]] <= cur_reg.pt;
        end
        rd_data_reg <= kept_mem[issue_idx_reg[rpt_pkg::ADDR_W-1:0]];
    end

    assign out_valid    = out_valid_reg;
    assign out_x        = out_pt_reg.x;
    assign out_y        = out_pt_reg.y;
    assign out_z        = out_pt_reg.z;
    assign keep         = keep_reg;
    assign table_full   = full_reg;
    assign end_of_cloud = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rpt_pkg::CNT_W'(rpt_pkg::MAX_KEPT))
        else $error("kept count beyond table size");

    a_keep_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(keep_reg && full_reg))
        else $error("keep and table_full both set");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> (state_reg == ST_SCAN))
        else $error("scan pipeline busy outside a scan");

    a_count_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && cur_reg.last) |=> (count_reg == '0))
        else $error("table not emptied after end of cloud");

endmodule

/* src/radius_point_thinning.sv */
`timescale 1ns / 1ps

// radius_point_thinning: greedy radius thinning of a 3d point stream
//
// input channel: in_valid / in_stall carry one point word (coord_x, coord_y,
// coord_z, last_point); a word is taken at a clock edge with in_valid high and
// in_stall low. every word yields exactly one output word, in order, on
// out_valid / out_stall: the same coordinates plus keep, table_full and
// end_of_cloud. a point is kept when its squared distance to every point kept
// so far in this cloud exceeds radius_squared and the table has room; the table
// empties after a word with last_point set.
//
// timing: a point is checked against the kept table one entry per cycle from
// the table memory, across the points kept so far in this cloud, and the scan
// ends early when an entry lies inside the radius.
// a two-word queue in front lets new points arrive while one is scanned, and
// an output register lets the next scan start while a result is held.
// cfg_write_en loads radius_squared; user must write while idle, not enforced.
// reset clears the kept count, the radius, the queue and the output valid.
// a stalled output word holds until taken; the scan of the next point then
// waits at its end, and the queue fills and raises in_stall.

module radius_point_thinning
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [rpt_pkg::RAD_W-1:0]            cfg_write_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [rpt_pkg::COORD_W-1:0]   coord_x,
    input  logic signed [rpt_pkg::COORD_W-1:0]   coord_y,
    input  logic signed [rpt_pkg::COORD_W-1:0]   coord_z,
    input  logic                                 last_point,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rpt_pkg::COORD_W-1:0]   out_x,
    output logic signed [rpt_pkg::COORD_W-1:0]   out_y,
    output logic signed [rpt_pkg::COORD_W-1:0]   out_z,
    output logic                                 keep,
    output logic                                 table_full,
    output logic                                 end_of_cloud
);

    // squared suppression radius
    logic [rpt_pkg::RAD_W-1:0]   radius_reg;
    logic [rpt_pkg::RAD_W-1:0]   radius_next;

    // queue head toward the scan engine
    rpt_pkg::queue_head_t        head;
    logic                        pop;

    assign radius_next = cfg_write_en ? cfg_write_data : radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
        end
        else
        begin
            radius_reg <= radius_next;
        end
    end

    // front: takes input words into the queue
    rpt_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .last_point (last_point),
        .head       (head),
        .pop        (pop)
    );

    // back: table scan, decision, table update and output register
    rpt_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .radius_squared (radius_reg),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .keep           (keep),
        .table_full     (table_full),
        .end_of_cloud   (end_of_cloud)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    // one checked output word: the point passed through plus the three flags
    typedef struct {
        rpt_pkg::point_t pt;
        logic            keep;
        logic            full;
        logic            last;
    } thin_word_t;

    // worst case per word: a full table scan plus the longest gap on each side,
    // taken over every word the run can send, then several times over
    localparam longint CYCLE_LIMIT =
        64'd4 * 2000 * (rpt_pkg::MAX_KEPT + 4 + 2 * 60) + 10000;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_write_en = 1'b0;
    logic [rpt_pkg::RAD_W-1:0]           cfg_write_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic signed [rpt_pkg::COORD_W-1:0]  coord_x = '0;
    logic signed [rpt_pkg::COORD_W-1:0]  coord_y = '0;
    logic signed [rpt_pkg::COORD_W-1:0]  coord_z = '0;
    logic                                last_point = 1'b0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [rpt_pkg::COORD_W-1:0]  out_x;
    logic signed [rpt_pkg::COORD_W-1:0]  out_y;
    logic signed [rpt_pkg::COORD_W-1:0]  out_z;
    logic                                keep;
    logic                                table_full;
    logic                                end_of_cloud;

    radius_point_thinning DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .coord_z        (coord_z),
        .last_point     (last_point),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .keep           (keep),
        .table_full     (table_full),
        .end_of_cloud   (end_of_cloud)
    );

    // 20 ns clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor state: our own copy of the kept table and the radius
    // ------------------------------------------------------------------
    rpt_pkg::point_t            kept_table [rpt_pkg::MAX_KEPT];
    int                         kept_n = 0;
    logic [rpt_pkg::RAD_W-1:0]  radius_sq = '0;

    rpt_pkg::item_t  pending_points [$];   // words waiting for the driver
    thin_word_t      expected_words [$];   // predicted output words, oldest first

    int failures = 0;
    int words_checked = 0;
    int kept_seen = 0;
    int suppressed_seen = 0;
    int full_seen = 0;
    int clouds_seen = 0;
    int radius_writes = 0;

    // greedy thinning of one point against the points kept so far
    function automatic thin_word_t thin_point(rpt_pkg::item_t it);
        thin_word_t r;
        bit         near_hit;
        longint     dx;
        longint     dy;
        longint     dz;
        near_hit = 1'b0;
        for (int i = 0; i < kept_n && !near_hit; i++)
        begin
            dx = longint'($signed(it.pt.x)) - longint'($signed(kept_table[i].x));
            dy = longint'($signed(it.pt.y)) - longint'($signed(kept_table[i].y));
            dz = longint'($signed(it.pt.z)) - longint'($signed(kept_table[i].z));
            // equal distance suppresses, so the compare is inclusive
            if (dx * dx + dy * dy + dz * dz <= longint'(radius_sq))
                near_hit = 1'b1;
        end
        r.pt   = it.pt;
        r.keep = 1'b0;
        r.full = 1'b0;
        r.last = it.last;
        if (!near_hit)
        begin
            if (kept_n < rpt_pkg::MAX_KEPT)
            begin
                kept_table[kept_n] = it.pt;
                kept_n = kept_n + 1;
                r.keep = 1'b1;
            end
            else
                r.full = 1'b1;   // would survive but there is no room
        end
        // the marked word is judged first, then the table empties
        if (it.last)
            kept_n = 0;
        return r;
    endfunction

    // idle lengths: mostly none or short, now and then long
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // input driver: one word at a time from pending_points, with gaps
    // ------------------------------------------------------------------
    rpt_pkg::item_t on_bus;
    int             in_gap = 0;
    int             in_calm = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            // word taken at this edge: predict its output word now
            if (in_valid && !in_stall)
                expected_words.push_back(thin_point(on_bus));
            // payload may only change when nothing is held on the bus
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_points.size() != 0)
                begin
                    on_bus = pending_points.pop_front();
                    coord_x    <= on_bus.pt.x;
                    coord_y    <= on_bus.pt.y;
                    coord_z    <= on_bus.pt.z;
                    last_point <= on_bus.last;
                    in_valid   <= 1'b1;
                    // occasional runs with no gaps at all
                    if (in_calm > 0)
                    begin
                        in_calm = in_calm - 1;
                        in_gap = 0;
                    end
                    else
                    begin
                        in_gap = draw_gap();
                        if ($urandom_range(0, 39) == 0)
                            in_calm = $urandom_range(20, 80);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor: random stall, compare against the oldest prediction
    // ------------------------------------------------------------------
    thin_word_t want;
    int         out_hold = 0;
    int         out_calm = 0;

    task automatic check_field(input string name, input logic signed [31:0] exp_val,
                               input logic signed [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("output word with no prediction waiting");
                    failures++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("out_x", want.pt.x, out_x);
                    check_field("out_y", want.pt.y, out_y);
                    check_field("out_z", want.pt.z, out_z);
                    check_field("keep", want.keep, keep);
                    check_field("table_full", want.full, table_full);
                    check_field("end_of_cloud", want.last, end_of_cloud);
                    words_checked++;
                    if (want.keep)
                        kept_seen++;
                    else if (want.full)
                        full_seen++;
                    else
                        suppressed_seen++;
                    if (want.last)
                        clouds_seen++;
                end
            end
            // stall bursts of random length, with calm stretches between
            if (out_hold > 0)
            begin
                out_stall <= 1'b1;
                out_hold = out_hold - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_calm > 0)
                    out_calm = out_calm - 1;
                else if ($urandom_range(0, 3) == 0)
                begin
                    out_hold = draw_gap();
                    if ($urandom_range(0, 49) == 0)
                        out_calm = $urandom_range(30, 200);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_point(input int px, input int py, input int pz, input bit last);
        rpt_pkg::item_t it;
        it.pt.x = px[rpt_pkg::COORD_W-1:0];
        it.pt.y = py[rpt_pkg::COORD_W-1:0];
        it.pt.z = pz[rpt_pkg::COORD_W-1:0];
        it.last = last;
        pending_points.push_back(it);
    endtask

    // block idle: nothing queued, nothing on the bus, nothing outstanding
    task automatic wait_idle();
        while (pending_points.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // radius register write, only ever issued while idle
    task automatic write_radius(input logic [rpt_pkg::RAD_W-1:0] v);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        radius_sq = v;
        radius_writes++;
    endtask

    // offset one axis by +/- e, folding back if it would leave the 16-bit range
    function automatic int step_axis(input int q, input int e);
        int s;
        s = ($urandom_range(0, 1) != 0) ? -e : e;
        if (q + s > 32767 || q + s < -32768)
            return q - s;
        return q + s;
    endfunction

    // global timeout
    longint cycle_count = 0;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rpt_pkg::point_t            cloud_pts [$];
        rpt_pkg::point_t            q;
        logic [63:0]                wide;
        logic [rpt_pkg::RAD_W-1:0]  rad;
        int spread;
        int ea;
        int eb;
        int ec;
        int cx;
        int cy;
        int cz;
        int px;
        int py;
        int pz;
        int mode;
        int cloud_len;
        int phase_words;
        int random_words;
        int first_y;
        int first_z;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // radius 25: exact-radius neighbor, just-outside neighbor, corner points
        write_radius(34'd25);
        queue_point(0, 0, 0, 1'b0);
        queue_point(3, 4, 0, 1'b0);            // distance equals radius, suppressed
        queue_point(3, 4, 1, 1'b0);            // one past the radius, kept
        queue_point(-32768, -32768, -32768, 1'b0);
        queue_point(32767, 32767, 32767, 1'b0);
        queue_point(32767, 32767, 32762, 1'b1); // exact radius from the far corner
        wait_idle();

        // radius zero: a duplicate still suppresses
        write_radius('0);
        queue_point(100, -200, 300, 1'b0);
        queue_point(100, -200, 300, 1'b0);
        queue_point(100, -200, 301, 1'b1);
        wait_idle();

        // largest radius: the widest possible distance is still inside
        write_radius({rpt_pkg::RAD_W{1'b1}});
        queue_point(-32768, 32767, -32768, 1'b0);
        queue_point(32767, -32768, 32767, 1'b0);
        queue_point(0, 0, 0, 1'b1);
        wait_idle();

        // fill the kept table completely with distinct points, then overflow it
        write_radius('0);
        first_y = int'($urandom_range(0, 65535)) - 32768;
        first_z = int'($urandom_range(0, 65535)) - 32768;
        queue_point(-512, first_y, first_z, 1'b0);
        for (int i = 1; i < rpt_pkg::MAX_KEPT; i++)
            queue_point(i - 512, int'($urandom_range(0, 65535)) - 32768,
                        int'($urandom_range(0, 65535)) - 32768, 1'b0);
        queue_point(600, 0, 0, 1'b0);                // no room, flagged full
        queue_point(-512, first_y, first_z, 1'b0);  // duplicate, plain suppress
        queue_point(-1000, 5, 5, 1'b1);              // no room, ends the cloud
        wait_idle();

        // random phases: new radius each phase, clustered clouds
        random_words = 0;
        while (random_words < 580)
        begin
            case ($urandom_range(0, 4))
                0: spread = 2;
                1: spread = 16;
                2: spread = 300;
                3: spread = 5000;
                default: spread = 16383;
            endcase
            ea = $urandom_range(0, spread);
            eb = $urandom_range(0, spread);
            ec = $urandom_range(0, spread);
            mode = $urandom_range(0, 19);
            if (mode < 8)
                rad = rpt_pkg::RAD_W'(longint'(ea) * ea + longint'(eb) * eb
                                      + longint'(ec) * ec);
            else if (mode < 12)
                rad = rpt_pkg::RAD_W'($urandom_range(0, 3 * spread * spread));
            else if (mode < 15)
            begin
                wide = {$urandom, $urandom};
                rad = wide[rpt_pkg::RAD_W-1:0];
            end
            else if (mode < 17)
                rad = '0;
            else
                rad = {rpt_pkg::RAD_W{1'b1}};
            write_radius(rad);

            phase_words = 0;
            while (phase_words < 50)
            begin
                cloud_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 30);
                cx = int'($urandom_range(0, 32767)) - 16384;
                cy = int'($urandom_range(0, 32767)) - 16384;
                cz = int'($urandom_range(0, 32767)) - 16384;
                cloud_pts.delete();
                for (int k = 0; k < cloud_len; k++)
                begin
                    mode = $urandom_range(0, 99);
                    if (cloud_pts.size() != 0)
                        q = cloud_pts[$urandom_range(0, cloud_pts.size() - 1)];
                    if (mode < 60 || (cloud_pts.size() == 0 && mode < 85))
                    begin
                        // near the cloud center, distances comparable to the radius
                        px = cx + int'($urandom_range(0, 2 * spread)) - spread;
                        py = cy + int'($urandom_range(0, 2 * spread)) - spread;
                        pz = cz + int'($urandom_range(0, 2 * spread)) - spread;
                    end
                    else if (mode < 72)
                    begin
                        // repeat of an earlier point
                        px = $signed(q.x);
                        py = $signed(q.y);
                        pz = $signed(q.z);
                    end
                    else if (mode < 85)
                    begin
                        // offset that lands on the radius when it was built from it
                        px = step_axis($signed(q.x), ea);
                        py = step_axis($signed(q.y), eb);
                        pz = step_axis($signed(q.z), ec);
                    end
                    else
                    begin
                        // anywhere in the coordinate range
                        px = int'($urandom_range(0, 65535)) - 32768;
                        py = int'($urandom_range(0, 65535)) - 32768;
                        pz = int'($urandom_range(0, 65535)) - 32768;
                    end
                    q.x = px[rpt_pkg::COORD_W-1:0];
                    q.y = py[rpt_pkg::COORD_W-1:0];
                    q.z = pz[rpt_pkg::COORD_W-1:0];
                    cloud_pts.push_back(q);
                    queue_point(px, py, pz, k == cloud_len - 1);
                end
                phase_words += cloud_len;
            end
            random_words += phase_words;
            wait_idle();
        end

        // drain, then give any stray word time to show up
        wait_idle();
        repeat (2 * (rpt_pkg::MAX_KEPT + 4)) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $error("%0d predicted words never arrived", expected_words.size());
            failures++;
        end

        $display("checked %0d words in %0d clouds over %0d radius settings",
                 words_checked, clouds_seen, radius_writes);
        $display("kept %0d, suppressed %0d, dropped on full table %0d",
                 kept_seen, suppressed_seen, full_seen);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* radius_point_thinning.f */
src/rpt_pkg.sv
src/rpt_front.sv
src/rpt_back.sv
src/radius_point_thinning.sv
tb/tb.sv
